// ----- hw/rtl/sxf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxf_pkg
// shared types, codes and helpers of the sprite xor frame buffer
// ----------------------------------------------------------------------------
package sxf_pkg;

  localparam int ScreenWidthDefault  = 64;
  localparam int ScreenHeightDefault = 32;
  localparam int MaxSpriteRows       = 16;
  localparam int ReadCols            = 64;
  localparam int SpriteBits          = 8;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } sxf_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR
  } sxf_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] origin_x;
    logic [4:0] origin_y;
    logic [3:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } sxf_cmd_t;

  typedef struct packed {
    logic        collision;
    logic        sprite_done;
    logic [63:0] pixel_row;
  } sxf_result_t;

  // remainder of a narrow value by a constant modulus, restoring form,
  // good for quotients below 32
  function automatic logic [7:0] mod_narrow(input logic [7:0] value, input int modulus);
    logic [7:0] v;
    v = value;
    for (int s = 4; s >= 0; s--) begin
      if (int'(v) >= (modulus << s)) begin
        v = v - 8'(modulus << s);
      end
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/sxf_row_xor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxf_row_xor
// toggles the eight sprite pixels of one frame-buffer row and flags collision
// ----------------------------------------------------------------------------
module sxf_row_xor #(
  parameter int SCREEN_WIDTH = sxf_pkg::ScreenWidthDefault
) (
  input  logic [5:0]              origin_x,
  input  logic [7:0]              row_bits,
  input  logic [SCREEN_WIDTH-1:0] row_old,
  output logic [SCREEN_WIDTH-1:0] row_new,
  output logic                    hit
);
  import sxf_pkg::*;

  logic [7:0]              x_wrap;
  logic [7:0]              col [SpriteBits];
  logic [SCREEN_WIDTH-1:0] mask;

  // column of each sprite bit, msb first, wrapped at the screen edge
  always_comb begin
    x_wrap = mod_narrow({2'b00, origin_x}, SCREEN_WIDTH);
    for (int k = 0; k < SpriteBits; k++) begin
      col[k] = mod_narrow(x_wrap + 8'(k), SCREEN_WIDTH);
    end
  end

  // word bit SCREEN_WIDTH-1 holds column 0
  always_comb begin
    mask = '0;
    for (int c = 0; c < SCREEN_WIDTH; c++) begin
      for (int k = 0; k < SpriteBits; k++) begin
        if (row_bits[SpriteBits-1-k] && (col[k] == 8'(c))) begin
          mask[SCREEN_WIDTH-1-c] = 1'b1;
        end
      end
    end
  end

  assign row_new = row_old ^ mask;
  assign hit     = |(row_old & mask);

endmodule

// ----- hw/rtl/sprite_xor_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer
// monochrome frame buffer with xor sprite drawing, clear and row readout
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low. Draw and read
// items first read the addressed row from the frame-buffer memory, then xor
// in the sprite byte and write the row back (or return the row). Clear takes
// the item, then sweeps the memory one row per cycle. An undefined operation
// is answered straight from idle. Every item gives exactly one result, shown
// for a single cycle with result_strobe high; the receiver cannot hold it off
// and must take it then. After reset the buffer reads as all zero right away:
// a per-row valid bit masks rows that were never written, so no clearing pass
// runs after reset. Collision accumulates over the draw items of one sprite
// and is reported and cleared on the item with last_row set; clear leaves it
// untouched.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer #(
  parameter int SCREEN_WIDTH  = sxf_pkg::ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = sxf_pkg::ScreenHeightDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sxf_pkg::sxf_cmd_t    command,
  output logic                result_strobe,
  output sxf_pkg::sxf_result_t result
);
  import sxf_pkg::*;

  localparam int RowBits = $clog2(SCREEN_HEIGHT);
  localparam int OutCols = (SCREEN_WIDTH < ReadCols) ? SCREEN_WIDTH : ReadCols;

  // frame-buffer memory, one word per screen row
  logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0] mem_q;
  logic [SCREEN_WIDTH-1:0] mem_wdata;
  logic [RowBits-1:0]      mem_raddr;
  logic [RowBits-1:0]      mem_waddr;
  logic                    mem_we;

  // rows written since reset; an unwritten row reads as zero
  logic [SCREEN_HEIGHT-1:0] row_valid;

  // control
  sxf_state_t         state, state_next;
  sxf_cmd_t           cmd_q;
  logic [RowBits-1:0] row_q;
  logic [RowBits-1:0] clr_addr, clr_addr_next;
  logic               coll_acc, coll_acc_next;
  logic               accept;

  // result staging
  logic        strobe_next;
  sxf_result_t result_next;

  // row addressing of the incoming item
  logic [7:0]         idx_wrap;
  logic [7:0]         draw_row;
  logic [7:0]         read_row;
  logic [RowBits-1:0] item_row;

  // datapath
  logic [SCREEN_WIDTH-1:0] row_eff;
  logic [SCREEN_WIDTH-1:0] row_new;
  logic                    hit;
  logic [63:0]             pixels;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // sprite row and read row, both wrapped to the screen height
  always_comb begin
    idx_wrap = mod_narrow({4'b0000, command.row_index}, MaxSpriteRows);
    draw_row = mod_narrow({3'b000, command.origin_y} + idx_wrap, SCREEN_HEIGHT);
    read_row = mod_narrow({3'b000, command.origin_y}, SCREEN_HEIGHT);
    if (command.operation == OP_READ) begin
      item_row = read_row[RowBits-1:0];
    end else begin
      item_row = draw_row[RowBits-1:0];
    end
  end

  assign mem_raddr = item_row;

  // row as stored, with never-written rows forced to zero
  assign row_eff = row_valid[row_q] ? mem_q : '0;

  sxf_row_xor #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_row_xor (
    .origin_x(cmd_q.origin_x),
    .row_bits(cmd_q.row_bits),
    .row_old (row_eff),
    .row_new (row_new),
    .hit     (hit)
  );

  // readout: bit 63 is column 0, columns past the screen width are zero
  always_comb begin
    pixels = '0;
    for (int c = 0; c < OutCols; c++) begin
      pixels[ReadCols-1-c] = row_eff[SCREEN_WIDTH-1-c];
    end
  end

  // synchronous memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= frame_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[mem_waddr] <= 1'b1;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      clr_addr      <= '0;
      coll_acc      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      coll_acc      <= coll_acc_next;
      result_strobe <= strobe_next;
    end
  end

  // item payload and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      row_q <= item_row;
    end
    if (strobe_next) begin
      result <= result_next;
    end
  end

  // next state, memory control and result
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    coll_acc_next = coll_acc;
    strobe_next   = 1'b0;
    result_next   = '0;
    mem_we        = 1'b0;
    mem_waddr     = row_q;
    mem_wdata     = row_new;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command.operation)
            OP_DRAW, OP_READ: begin
              state_next = ST_ACCESS;
            end
            OP_CLEAR: begin
              state_next    = ST_CLEAR;
              clr_addr_next = '0;
            end
            default: begin
              // undefined operation: empty result, nothing changes
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        // memory data for row_q is valid now
        state_next  = ST_IDLE;
        strobe_next = 1'b1;
        if (cmd_q.operation == OP_READ) begin
          result_next.pixel_row = pixels;
        end else begin
          mem_we = 1'b1;
          if (cmd_q.last_row) begin
            result_next.collision   = coll_acc | hit;
            result_next.sprite_done = 1'b1;
            coll_acc_next           = 1'b0;
          end else begin
            coll_acc_next = coll_acc | hit;
          end
        end
      end

      ST_CLEAR: begin
        // zero one row per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == RowBits'(SCREEN_HEIGHT - 1)) begin
          state_next  = ST_IDLE;
          strobe_next = 1'b1;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // draw and read items raise result_strobe after passing through ST_ACCESS
  a_access_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (command.operation == OP_DRAW || command.operation == OP_READ))
      |=> ##1 result_strobe)
    else $error("draw or read result missing two cycles after start");

  // an undefined operation answers at once with an empty result
  a_undefined_op: assert property (@(posedge clk) disable iff (rst)
    (accept && command.operation != OP_DRAW && command.operation != OP_CLEAR &&
     command.operation != OP_READ) |=> (result_strobe && result == '0))
    else $error("undefined operation gave a wrong result");

  // collision is only reported together with the end of a sprite
  a_collision_done: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.sprite_done) |-> !result.collision)
    else $error("collision reported without sprite_done");

  // pixel data only follows a memory access
  a_pixels_source: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.pixel_row != '0) |-> $past(state == ST_ACCESS))
    else $error("pixel data without a row read");

endmodule

// ----- verif/sprite_xor_framebuffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_tb
// self-checking bench for the xor sprite frame buffer
// ----------------------------------------------------------------------------
// Commands are driven over the start/busy handshake and every accepted item
// is fed to a bit-level model of the 64x32 buffer and the collision flag.
// Each strobed result is checked field by field against the oldest
// prediction. A short directed run covers wrap-around, collisions, clear in
// mid-sprite and the undefined opcode. It is followed by random sprites,
// reads, clears and noise, with random idle bursts on the sending side.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer_tb;
  import sxf_pkg::*;

  localparam logic [1:0] OP_UNDEF = 2'd3;   // no such operation in the block
  localparam int NumRandomItems = 700;
  localparam int QuietTail = 150;           // items at the end with no idling
  localparam int StallLimit = 2000;         // cycles with no handshake at all
  localparam int DrainCycles = 40;          // a clear sweeps 32 rows

  // model of the frame buffer plus the queue of predicted results
  class framebuffer_scoreboard;
    logic [63:0] pixels [32];   // bit 63 is column 0
    logic        collision_acc;
    sxf_result_t predicted_q [$];
    int          errors;

    function new();
      foreach (pixels[r]) pixels[r] = '0;
      collision_acc = 1'b0;
      errors = 0;
    endfunction

    // apply one accepted command to the model and queue its result
    function void note_command(sxf_cmd_t c);
      sxf_result_t res;
      int          row;
      int          col;
      res = '0;
      case (c.operation)
        OP_DRAW: begin
          row = (int'(c.origin_y) + int'(c.row_index) % MaxSpriteRows) % 32;
          for (int k = 0; k < SpriteBits; k++) begin
            if (c.row_bits[7 - k]) begin
              col = (int'(c.origin_x) + k) % 64;
              if (pixels[row][63 - col]) collision_acc = 1'b1;
              pixels[row][63 - col] = ~pixels[row][63 - col];
            end
          end
          if (c.last_row) begin
            res.collision   = collision_acc;
            res.sprite_done = 1'b1;
            collision_acc   = 1'b0;
          end
        end
        OP_CLEAR: begin
          foreach (pixels[r]) pixels[r] = '0;
        end
        OP_READ: begin
          res.pixel_row = pixels[int'(c.origin_y) % 32];
        end
        default: ;
      endcase
      predicted_q.push_back(res);
    endfunction

    function void check_result(sxf_result_t r);
      sxf_result_t e;
      if (predicted_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, r);
        errors++;
        return;
      end
      e = predicted_q.pop_front();
      if (r.collision !== e.collision) begin
        $display("%0t: collision expected %b actual %b", $time, e.collision, r.collision);
        errors++;
      end
      if (r.sprite_done !== e.sprite_done) begin
        $display("%0t: sprite_done expected %b actual %b", $time,
                 e.sprite_done, r.sprite_done);
        errors++;
      end
      if (r.pixel_row !== e.pixel_row) begin
        $display("%0t: pixel_row expected %h actual %h", $time, e.pixel_row, r.pixel_row);
        errors++;
      end
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  sxf_cmd_t    command = '0;
  logic        result_strobe;
  sxf_result_t result;

  framebuffer_scoreboard sb;
  int  items_sent = 0;
  bit  idle_on = 1'b0;
  int  stall_cycles = 0;

  sprite_xor_framebuffer u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: check the result before noting a new item, so a result can
  // never be matched against an item accepted on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_result(result);
      if (start && !busy) sb.note_command(command);
    end
  end

  // watchdog on cycles with neither an accepted item nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic sxf_cmd_t make_cmd(logic [1:0] op, logic [5:0] x, logic [4:0] y,
                                        logic [3:0] idx, logic [7:0] bits, logic last);
    sxf_cmd_t c;
    c.operation = op;
    c.origin_x  = x;
    c.origin_y  = y;
    c.row_index = idx;
    c.row_bits  = bits;
    c.last_row  = last;
    return c;
  endfunction

  function automatic sxf_cmd_t random_fields(logic [1:0] op);
    return make_cmd(op, 6'($urandom), 5'($urandom), 4'($urandom), 8'($urandom),
                    1'($urandom));
  endfunction

  // present one item and hold it until the block takes it; start stays high
  // afterwards so back-to-back items need no extra edge
  task automatic send_item(sxf_cmd_t c);
    start   <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // optional idle burst after an accepted item
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send(sxf_cmd_t c);
    send_item(c);
    maybe_idle();
  endtask

  // hold off until the block has returned everything
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // one well-formed sprite with random content, rows 0..n-1, last on the end
  task automatic draw_sprite();
    int          rows;
    logic [5:0]  x;
    logic [4:0]  y;
    logic [7:0]  bits;
    x = 6'($urandom);
    y = 5'($urandom);
    rows = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
    for (int i = 0; i < rows; i++) begin
      case ($urandom_range(0, 7))
        0:       bits = 8'hff;
        1:       bits = 8'h00;
        default: bits = 8'($urandom);
      endcase
      send(make_cmd(OP_DRAW, x, y, 4'(i), bits, i == rows - 1));
      // a read between rows must not disturb the collision flag
      if ($urandom_range(0, 15) == 0) send(random_fields(OP_READ));
    end
  endtask

  initial begin
    int  choice;
    bit  drained_mid;
    sb = new();
    drained_mid = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty buffer, overdraw collision, wrap in x and y
    send(make_cmd(OP_READ, 6'd0, 5'd0, 4'd0, 8'd0, 1'b0));
    send(make_cmd(OP_DRAW, 6'd0, 5'd0, 4'd0, 8'hff, 1'b0));
    send(make_cmd(OP_DRAW, 6'd0, 5'd0, 4'd0, 8'hf0, 1'b1));
    send(make_cmd(OP_READ, 6'd63, 5'd0, 4'd15, 8'hff, 1'b1));
    send(make_cmd(OP_DRAW, 6'd60, 5'd31, 4'd15, 8'ha5, 1'b1));
    send(make_cmd(OP_READ, 6'd0, 5'd30, 4'd0, 8'd0, 1'b0));
    send(make_cmd(OP_DRAW, 6'd63, 5'd31, 4'd1, 8'h81, 1'b0));
    send(make_cmd(OP_DRAW, 6'd63, 5'd31, 4'd15, 8'hff, 1'b1));
    send(make_cmd(OP_READ, 6'd0, 5'd31, 4'd0, 8'd0, 1'b0));
    send(make_cmd(OP_READ, 6'd0, 5'd0, 4'd0, 8'd0, 1'b0));
    // collision before a clear must still be reported on the last row
    send(make_cmd(OP_DRAW, 6'd10, 5'd5, 4'd0, 8'h3c, 1'b0));
    send(make_cmd(OP_DRAW, 6'd10, 5'd5, 4'd0, 8'h18, 1'b0));
    send(make_cmd(OP_CLEAR, 6'd63, 5'd31, 4'd15, 8'hff, 1'b1));
    send(make_cmd(OP_DRAW, 6'd10, 5'd5, 4'd1, 8'h00, 1'b1));
    send(make_cmd(OP_READ, 6'd0, 5'd5, 4'd0, 8'd0, 1'b0));
    // undefined opcode with every field at its top
    send(make_cmd(OP_UNDEF, 6'd63, 5'd31, 4'd15, 8'hff, 1'b1));
    send(make_cmd(OP_UNDEF, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0));
    send(make_cmd(OP_DRAW, 6'd63, 5'd31, 4'd15, 8'hff, 1'b1));
    send(make_cmd(OP_READ, 6'd63, 5'd14, 4'd0, 8'd0, 1'b0));
    send(make_cmd(OP_DRAW, 6'd0, 5'd0, 4'd0, 8'h00, 1'b1));
    drain();

    // random: mostly whole sprites, with reads, rare clears and noise
    while (items_sent < NumRandomItems) begin
      idle_on = (items_sent < NumRandomItems - QuietTail) && ($urandom_range(0, 3) != 0);
      if (!drained_mid && items_sent > NumRandomItems / 2) begin
        drain();
        drained_mid = 1'b1;
      end
      choice = $urandom_range(0, 99);
      if (choice < 60) draw_sprite();
      else if (choice < 80) send(random_fields(OP_READ));
      else if (choice < 83) send(random_fields(OP_CLEAR));
      else if (choice < 88) send(random_fields(OP_UNDEF));
      else send(random_fields(2'($urandom)));
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
